/* rtl/cibc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cibc_pkg
// Payload types and fixed codes of the interrupt and branch control unit.
// ----------------------------------------------------------------------------
package cibc_pkg;

  // Commands carried by an input item.
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_WR_IE    = 2'd1;
  localparam logic [1:0] CMD_WR_IF    = 2'd2;
  localparam logic [1:0] CMD_REQUEST  = 2'd3;

  // Instruction classes.
  localparam logic [3:0] FOP_OTHER    = 4'd0;
  localparam logic [3:0] FOP_JP_CC    = 4'd1;
  localparam logic [3:0] FOP_JP_HL    = 4'd2;
  localparam logic [3:0] FOP_JP       = 4'd3;
  localparam logic [3:0] FOP_JR_CC    = 4'd4;
  localparam logic [3:0] FOP_JR       = 4'd5;
  localparam logic [3:0] FOP_CALL_CC  = 4'd6;
  localparam logic [3:0] FOP_CALL     = 4'd7;
  localparam logic [3:0] FOP_RET      = 4'd8;
  localparam logic [3:0] FOP_RET_CC   = 4'd9;
  localparam logic [3:0] FOP_RST      = 4'd10;
  localparam logic [3:0] FOP_EI_DI    = 4'd11;
  localparam logic [3:0] FOP_RETI     = 4'd12;
  localparam logic [3:0] FOP_HALT     = 4'd13;
  localparam logic [3:0] FOP_NOP      = 4'd14;
  localparam logic [3:0] FOP_UNKNOWN  = 4'd15;

  // Branch conditions in opcode bits 4:3.
  localparam logic [1:0] CC_NZ        = 2'd0;
  localparam logic [1:0] CC_Z         = 2'd1;
  localparam logic [1:0] CC_NC        = 2'd2;
  localparam logic [1:0] CC_C         = 2'd3;

  // Stack requests.
  localparam logic [1:0] STK_NONE     = 2'd0;
  localparam logic [1:0] STK_PUSH     = 2'd1;
  localparam logic [1:0] STK_POP      = 2'd2;

  // Kinds of step reported with each result.
  localparam logic [2:0] KIND_BUSY    = 3'd0;
  localparam logic [2:0] KIND_HALTED  = 3'd1;
  localparam logic [2:0] KIND_INSN    = 3'd2;
  localparam logic [2:0] KIND_IRQ     = 3'd3;
  localparam logic [2:0] KIND_REG     = 3'd4;

  localparam logic [15:0] VECTOR_BASE = 16'h0040;
  localparam logic [7:0]  BUSY_MAX    = 8'd255;
  localparam logic [3:0]  IDLE_RESET  = 4'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  req_line;
    logic [7:0]  wdata;
    logic [3:0]  flow_op;
    logic [7:0]  opcode;
    logic [1:0]  length;
    logic [2:0]  base_cycles;
    logic [1:0]  extra_cycles;
    logic [15:0] immediate;
    logic [15:0] hl_value;
    logic [1:0]  zc_flags;
    logic [15:0] pop_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pc_out;
    logic [1:0]  stack_op;
    logic [15:0] push_value;
    logic [2:0]  step_kind;
    logic        error_flag;
    logic        ime_out;
    logic        halted_out;
    logic [7:0]  enable_bits;
    logic [7:0]  flag_bits;
  } out_item_t;

endpackage

/* rtl/cpu_interrupt_and_branch_control_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_interrupt_and_branch_control_unit
// Interrupt dispatch and control-flow sequencing for a small 8-bit CPU.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one command item:
//   a tick with the decoded flow instruction, a write of IE or IF, or an
//   interrupt request. Each accepted item yields exactly one result item on
//   the output channel (out_valid/out_ready/out_data): the new PC, a stack
//   push or pop request, the kind of step and the interrupt state.
//   The cfg channel writes the busy cycles spent on taking an interrupt; it
//   is always ready. The user must write it only while the unit is idle;
//   the unit does not enforce this. One item is taken per cycle while
//   in_ready is high; the whole step (priority encode, condition test,
//   next PC) is one combinational pass ahead of the result register.
//   When the receiver stalls, the unit still takes one more item into a
//   skid register and then drops in_ready until the output drains.
//   Synchronous reset clears PC, IME, halt, busy count, IE and IF, sets the
//   interrupt busy count to 4 and empties the output side.
// ----------------------------------------------------------------------------
module cpu_interrupt_and_branch_control_unit
  import cibc_pkg::*;
#(
  parameter int NUM_SOURCES = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [3:0] cfg_data
);

  localparam logic [7:0] LINE_MASK = 8'((9'd1 << NUM_SOURCES) - 9'd1);
  localparam logic [3:0] NUM_SRC_W = 4'(NUM_SOURCES);

  logic [15:0] pc_r, pc_nxt;
  logic        ime_r, ime_nxt;
  logic        halt_r, halt_nxt;
  logic [7:0]  busy_r, busy_nxt;
  logic [7:0]  ie_r, ie_nxt;
  logic [7:0]  if_r, if_nxt;
  logic [3:0]  idle_r;

  logic        out_valid_r, skid_valid_r;
  out_item_t   out_data_r, skid_data_r, res;

  logic        in_fire;
  logic        out_free;
  logic [7:0]  live;
  logic [2:0]  irq_idx;
  logic [15:0] next_pc, rel_pc;
  logic        cond_ok;
  logic [4:0]  busy_add;
  logic [8:0]  busy_sum;

  assign in_ready  = ~skid_valid_r;
  assign in_fire   = in_valid & in_ready;
  assign out_free  = out_ready | ~out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign live    = ie_r & if_r & LINE_MASK;
  assign next_pc = pc_r + 16'(in_data.length);
  assign rel_pc  = next_pc + {{8{in_data.immediate[7]}}, in_data.immediate[7:0]};

  // Lowest pending line wins.
  always_comb begin
    irq_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (live[i]) begin
        irq_idx = 3'(i);
      end
    end
  end

  always_comb begin
    unique case (in_data.opcode[4:3])
      CC_NZ:   cond_ok = ~in_data.zc_flags[1];
      CC_Z:    cond_ok = in_data.zc_flags[1];
      CC_NC:   cond_ok = ~in_data.zc_flags[0];
      CC_C:    cond_ok = in_data.zc_flags[0];
      default: cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    ime_nxt  = ime_r;
    halt_nxt = halt_r;
    ie_nxt   = ie_r;
    if_nxt   = if_r;
    busy_add = '0;
    busy_sum = '0;
    res      = '0;
    busy_nxt = busy_r;

    unique case (in_data.cmd)
      CMD_WR_IE: begin
        ie_nxt        = in_data.wdata;
        res.step_kind = KIND_REG;
      end
      CMD_WR_IF: begin
        if_nxt        = in_data.wdata;
        res.step_kind = KIND_REG;
      end
      CMD_REQUEST: begin
        if ({1'b0, in_data.req_line} < NUM_SRC_W) begin
          if_nxt = if_r | (8'd1 << in_data.req_line);
        end
        res.step_kind = KIND_REG;
      end
      default: begin
        if (busy_r != 8'd0) begin
          busy_nxt      = busy_r - 8'd1;
          res.step_kind = KIND_BUSY;
        end else if (halt_r && live == 8'd0) begin
          res.step_kind = KIND_HALTED;
        end else begin
          halt_nxt = 1'b0;
          if (ime_r && live != 8'd0) begin
            ime_nxt        = 1'b0;
            if_nxt         = if_r & ~(8'd1 << irq_idx);
            res.stack_op   = STK_PUSH;
            res.push_value = pc_r;
            pc_nxt         = VECTOR_BASE + {10'd0, irq_idx, 3'd0};
            busy_add       = {1'b0, idle_r};
            res.step_kind  = KIND_IRQ;
          end else begin
            res.step_kind = KIND_INSN;
            pc_nxt        = next_pc;
            case (in_data.flow_op)
              FOP_JP_CC: begin
                if (cond_ok) begin
                  pc_nxt   = in_data.immediate;
                  busy_add = {3'd0, in_data.extra_cycles};
                end
              end
              FOP_JP_HL: pc_nxt = in_data.hl_value;
              FOP_JP:    pc_nxt = in_data.immediate;
              FOP_JR_CC: begin
                if (cond_ok) begin
                  pc_nxt   = rel_pc;
                  busy_add = {3'd0, in_data.extra_cycles};
                end
              end
              FOP_JR:    pc_nxt = rel_pc;
              FOP_CALL_CC: begin
                if (cond_ok) begin
                  res.stack_op   = STK_PUSH;
                  res.push_value = next_pc;
                  pc_nxt         = in_data.immediate;
                  busy_add       = {3'd0, in_data.extra_cycles};
                end
              end
              FOP_CALL: begin
                res.stack_op   = STK_PUSH;
                res.push_value = next_pc;
                pc_nxt         = in_data.immediate;
              end
              FOP_RET: begin
                res.stack_op = STK_POP;
                pc_nxt       = in_data.pop_value;
              end
              FOP_RET_CC: begin
                if (cond_ok) begin
                  res.stack_op = STK_POP;
                  pc_nxt       = in_data.pop_value;
                  busy_add     = {3'd0, in_data.extra_cycles};
                end
              end
              FOP_RST: begin
                res.stack_op   = STK_PUSH;
                res.push_value = next_pc;
                pc_nxt         = {10'd0, in_data.opcode[5:3], 3'd0};
              end
              FOP_EI_DI: ime_nxt = in_data.opcode[3];
              FOP_RETI: begin
                ime_nxt      = 1'b1;
                res.stack_op = STK_POP;
                pc_nxt       = in_data.pop_value;
              end
              FOP_HALT:  halt_nxt = 1'b1;
              FOP_UNKNOWN: begin
                // An unknown class leaves the PC and the busy count alone.
                pc_nxt         = pc_r;
                res.error_flag = 1'b1;
              end
              default: ;
            endcase
            if (in_data.flow_op != FOP_UNKNOWN && in_data.base_cycles != 3'd0) begin
              busy_add = busy_add + {2'd0, 3'(in_data.base_cycles - 3'd1)};
            end
          end
          busy_sum = {1'b0, busy_r} + {4'd0, busy_add};
          busy_nxt = busy_sum[8] ? BUSY_MAX : busy_sum[7:0];
        end
      end
    endcase

    res.pc_out      = pc_nxt;
    res.ime_out     = ime_nxt;
    res.halted_out  = halt_nxt;
    res.enable_bits = ie_nxt;
    res.flag_bits   = if_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= '0;
      ime_r        <= 1'b0;
      halt_r       <= 1'b0;
      busy_r       <= '0;
      ie_r         <= '0;
      if_r         <= '0;
      idle_r       <= IDLE_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        idle_r <= cfg_data;
      end
      if (in_fire) begin
        pc_r   <= pc_nxt;
        ime_r  <= ime_nxt;
        halt_r <= halt_nxt;
        busy_r <= busy_nxt;
        ie_r   <= ie_nxt;
        if_r   <= if_nxt;
      end
      if (out_free) begin
        out_valid_r  <= skid_valid_r | in_fire;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_fire) begin
      skid_data_r <= res;
    end
  end

endmodule

/* rtl/cibc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cibc_checker
// Port-level assertions for the interrupt and branch control unit.
// ----------------------------------------------------------------------------
module cibc_checker
  import cibc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A held result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Back-pressure on the input only comes from a full output side.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Taking an interrupt always pushes the PC and drops IME.
  a_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_kind == KIND_IRQ |->
      out_data.stack_op == STK_PUSH && !out_data.ime_out)
    else $error("interrupt taken without push or with IME set");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_flag |-> out_data.step_kind == KIND_INSN &&
      out_data.stack_op == STK_NONE)
    else $error("error flag on a step that is not an instruction");

endmodule

bind cpu_interrupt_and_branch_control_unit cibc_checker u_cibc_checker (.*);

/* verif/tb_cpu_interrupt_and_branch_control_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_interrupt_and_branch_control_unit
// Self-checking bench for the interrupt dispatch and branch control unit.
// A short table of directed items covers every flow class, the register
// commands, halt and wake-up, interrupt entry and the odd corners. Random
// items follow under several interrupt idle settings. Every result item is
// compared field by field against a cycle-free model of the unit kept here.
// Both channels stall at random, and the receiver holds off twice for long
// stretches so that the unit backs up onto its input.
// ----------------------------------------------------------------------------
module tb_cpu_interrupt_and_branch_control_unit;
  import cibc_pkg::*;

  localparam int SOURCES     = 5;
  localparam logic [7:0] SRC_MASK = 8'((1 << SOURCES) - 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 40;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [3:0] cfg_data = '0;

  // Tracked state of the unit.
  logic [15:0] cur_pc;
  logic        cur_ime;
  logic        cur_halt;
  logic [7:0]  busy_left;
  logic [7:0]  cur_ie;
  logic [7:0]  cur_if;
  logic [3:0]  irq_idle;

  out_item_t due_steps[$];
  dir_row_t  dir_rows[$];
  int        fail_count = 0;
  int        results_seen = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  int        long_hold_left = 0;
  int        hold_mark = 150;
  bit        quiet = 1'b0;

  cpu_interrupt_and_branch_control_unit #(
    .NUM_SOURCES(SOURCES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] busy_add(input logic [7:0] cur, input logic [4:0] n);
    logic [8:0] sum;
    sum = cur + n;
    return (sum > BUSY_MAX) ? BUSY_MAX : sum[7:0];
  endfunction

  function automatic logic cond_met(input logic [7:0] opc, input logic [1:0] zc);
    case (opc[4:3])
      CC_NZ:   return !zc[1];
      CC_Z:    return zc[1];
      CC_NC:   return !zc[0];
      default: return zc[0];
    endcase
  endfunction

  // Applies one item to the tracked state and returns the result it causes.
  function automatic out_item_t next_step_result(input in_item_t t);
    out_item_t   r;
    logic [7:0]  live;
    logic [15:0] nxt;
    logic [15:0] rel;
    logic        ok;
    int          idx;
    r = '0;
    case (t.cmd)
      CMD_WR_IE: begin
        cur_ie = t.wdata;
        r.step_kind = KIND_REG;
      end
      CMD_WR_IF: begin
        cur_if = t.wdata;
        r.step_kind = KIND_REG;
      end
      CMD_REQUEST: begin
        if (t.req_line < SOURCES) cur_if[t.req_line] = 1'b1;
        r.step_kind = KIND_REG;
      end
      default: begin
        live = cur_ie & cur_if & SRC_MASK;
        if (busy_left != 0) begin
          busy_left = busy_left - 8'd1;
          r.step_kind = KIND_BUSY;
        end else if (cur_halt && live == 0) begin
          r.step_kind = KIND_HALTED;
        end else begin
          cur_halt = 1'b0;
          if (cur_ime && live != 0) begin
            idx = 0;
            while (!live[idx]) idx++;
            cur_ime = 1'b0;
            cur_if[idx] = 1'b0;
            r.stack_op = STK_PUSH;
            r.push_value = cur_pc;
            cur_pc = VECTOR_BASE + 16'(idx * 8);
            busy_left = busy_add(busy_left, {1'b0, irq_idle});
            r.step_kind = KIND_IRQ;
          end else begin
            nxt = cur_pc + t.length;
            rel = nxt + {{8{t.immediate[7]}}, t.immediate[7:0]};
            ok = cond_met(t.opcode, t.zc_flags);
            r.step_kind = KIND_INSN;
            case (t.flow_op)
              FOP_JP_CC: begin
                cur_pc = ok ? t.immediate : nxt;
                if (ok) busy_left = busy_add(busy_left, {3'd0, t.extra_cycles});
              end
              FOP_JP_HL: cur_pc = t.hl_value;
              FOP_JP: cur_pc = t.immediate;
              FOP_JR_CC: begin
                cur_pc = ok ? rel : nxt;
                if (ok) busy_left = busy_add(busy_left, {3'd0, t.extra_cycles});
              end
              FOP_JR: cur_pc = rel;
              FOP_CALL_CC: begin
                if (ok) begin
                  r.stack_op = STK_PUSH;
                  r.push_value = nxt;
                  cur_pc = t.immediate;
                  busy_left = busy_add(busy_left, {3'd0, t.extra_cycles});
                end else begin
                  cur_pc = nxt;
                end
              end
              FOP_CALL: begin
                r.stack_op = STK_PUSH;
                r.push_value = nxt;
                cur_pc = t.immediate;
              end
              FOP_RET: begin
                r.stack_op = STK_POP;
                cur_pc = t.pop_value;
              end
              FOP_RET_CC: begin
                if (ok) begin
                  r.stack_op = STK_POP;
                  cur_pc = t.pop_value;
                  busy_left = busy_add(busy_left, {3'd0, t.extra_cycles});
                end else begin
                  cur_pc = nxt;
                end
              end
              FOP_RST: begin
                r.stack_op = STK_PUSH;
                r.push_value = nxt;
                cur_pc = {10'd0, t.opcode[5:3], 3'd0};
              end
              FOP_EI_DI: begin
                cur_ime = t.opcode[3];
                cur_pc = nxt;
              end
              FOP_RETI: begin
                cur_ime = 1'b1;
                r.stack_op = STK_POP;
                cur_pc = t.pop_value;
              end
              FOP_HALT: begin
                cur_halt = 1'b1;
                cur_pc = nxt;
              end
              FOP_UNKNOWN: r.error_flag = 1'b1;
              default: cur_pc = nxt;
            endcase
            if (t.flow_op != FOP_UNKNOWN && t.base_cycles != 0) begin
              busy_left = busy_add(busy_left, {2'd0, t.base_cycles - 3'd1});
            end
          end
        end
      end
    endcase
    r.pc_out = cur_pc;
    r.ime_out = cur_ime;
    r.halted_out = cur_halt;
    r.enable_bits = cur_ie;
    r.flag_bits = cur_if;
    return r;
  endfunction

  function automatic in_item_t insn(input logic [3:0] fop, input logic [7:0] opc,
                                    input logic [1:0] len, input logic [2:0] base,
                                    input logic [1:0] extra, input logic [15:0] imm,
                                    input logic [15:0] hl, input logic [1:0] zc,
                                    input logic [15:0] popv);
    in_item_t t;
    t = '0;
    t.cmd = CMD_TICK;
    t.flow_op = fop;
    t.opcode = opc;
    t.length = len;
    t.base_cycles = base;
    t.extra_cycles = extra;
    t.immediate = imm;
    t.hl_value = hl;
    t.zc_flags = zc;
    t.pop_value = popv;
    return t;
  endfunction

  function automatic in_item_t regop(input logic [1:0] cmd, input logic [2:0] req,
                                     input logic [7:0] wdata);
    in_item_t t;
    t = '0;
    t.cmd = cmd;
    t.req_line = req;
    t.wdata = wdata;
    return t;
  endfunction

  function automatic out_item_t res(input logic [15:0] pc, input logic [1:0] sop,
                                    input logic [15:0] pushv, input logic [2:0] kind,
                                    input logic err, input logic ime, input logic halt,
                                    input logic [7:0] ie, input logic [7:0] iflag);
    return '{pc, sop, pushv, kind, err, ime, halt, ie, iflag};
  endfunction

  function automatic in_item_t rand_item();
    in_item_t t;
    int       pick;
    t.wdata = 8'($urandom);
    t.opcode = 8'($urandom);
    t.length = 2'($urandom);
    t.extra_cycles = 2'($urandom);
    t.immediate = 16'($urandom);
    t.hl_value = 16'($urandom);
    t.zc_flags = 2'($urandom);
    t.pop_value = 16'($urandom);
    t.req_line = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, SOURCES - 1))
                                            : 3'($urandom_range(SOURCES, 7));
    t.base_cycles = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, 2));
    t.flow_op = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      t.cmd = CMD_WR_IE;
    end else if (pick < 13) begin
      t.cmd = CMD_WR_IF;
    end else if (pick < 28) begin
      t.cmd = CMD_REQUEST;
    end else begin
      t.cmd = CMD_TICK;
      // Extra EI items keep the master enable up so interrupts get taken.
      if (pick >= 90) begin
        t.flow_op = FOP_EI_DI;
        t.opcode[3] = 1'b1;
      end
    end
    return t;
  endfunction

  task automatic mismatch(input string field, input logic [15:0] want, input logic [15:0] got);
    $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
    fail_count++;
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.pc_out !== want.pc_out) mismatch("pc_out", want.pc_out, got.pc_out);
    if (got.stack_op !== want.stack_op) mismatch("stack_op", want.stack_op, got.stack_op);
    if (got.push_value !== want.push_value)
      mismatch("push_value", want.push_value, got.push_value);
    if (got.step_kind !== want.step_kind) mismatch("step_kind", want.step_kind, got.step_kind);
    if (got.error_flag !== want.error_flag)
      mismatch("error_flag", want.error_flag, got.error_flag);
    if (got.ime_out !== want.ime_out) mismatch("ime_out", want.ime_out, got.ime_out);
    if (got.halted_out !== want.halted_out)
      mismatch("halted_out", want.halted_out, got.halted_out);
    if (got.enable_bits !== want.enable_bits)
      mismatch("enable_bits", want.enable_bits, got.enable_bits);
    if (got.flag_bits !== want.flag_bits) mismatch("flag_bits", want.flag_bits, got.flag_bits);
  endtask

  // Offers one item and returns in the time step in which it was accepted,
  // with valid still high so that a following item follows without valid dropping.
  task automatic send_item(input in_item_t x, input bit typed, input out_item_t want);
    out_item_t guess;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    guess = next_step_result(x);
    due_steps.push_back(typed ? want : guess);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_idle(input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    irq_idle = value;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_item(rand_item(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_steps.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          fail_count++;
        end else begin
          check_result(out_data, due_steps.pop_front());
        end
        results_seen++;
      end
      // Two long hold-offs let the unit fill up and drop in_ready.
      if (long_hold_left != 0) begin
        out_ready <= 1'b0;
        long_hold_left--;
      end else if (results_seen == hold_mark) begin
        out_ready <= 1'b0;
        long_hold_left = HOLD_CYCLES;
        hold_mark = (hold_mark == 150) ? 700 : -1;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[cpu_interrupt_and_branch_control_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    cur_pc = '0;
    cur_ime = 1'b0;
    cur_halt = 1'b0;
    busy_left = '0;
    cur_ie = '0;
    cur_if = '0;
    irq_idle = IDLE_RESET;

    // Unknown class first: nothing moves and its cycle counts are ignored.
    dir_rows.push_back('{insn(FOP_UNKNOWN, 8'hFF, 2'd3, 3'd7, 2'd3, 16'hFFFF, 16'hFFFF,
                              2'b11, 16'hFFFF), 1'b1,
                         res(16'h0000, STK_NONE, 16'h0, KIND_INSN, 1'b1, 1'b0, 1'b0,
                             8'h00, 8'h00)});
    dir_rows.push_back('{insn(FOP_OTHER, 8'h00, 2'd3, 3'd1, 2'd0, 16'h0, 16'h0, 2'b00,
                              16'h0), 1'b1,
                         res(16'h0003, STK_NONE, 16'h0, KIND_INSN, 1'b0, 1'b0, 1'b0,
                             8'h00, 8'h00)});
    dir_rows.push_back('{insn(FOP_JP, 8'h00, 2'd3, 3'd1, 2'd0, 16'hFFFF, 16'h0, 2'b00,
                              16'h0), 1'b1,
                         res(16'hFFFF, STK_NONE, 16'h0, KIND_INSN, 1'b0, 1'b0, 1'b0,
                             8'h00, 8'h00)});
    dir_rows.push_back('{regop(CMD_WR_IE, 3'd0, 8'hFF), 1'b1,
                         res(16'hFFFF, STK_NONE, 16'h0, KIND_REG, 1'b0, 1'b0, 1'b0,
                             8'hFF, 8'h00)});
    // Flags above the implemented sources must never wake or interrupt.
    dir_rows.push_back('{regop(CMD_WR_IF, 3'd0, 8'hE0), 1'b1,
                         res(16'hFFFF, STK_NONE, 16'h0, KIND_REG, 1'b0, 1'b0, 1'b0,
                             8'hFF, 8'hE0)});
    dir_rows.push_back('{regop(CMD_REQUEST, 3'd7, 8'h00), 1'b1,
                         res(16'hFFFF, STK_NONE, 16'h0, KIND_REG, 1'b0, 1'b0, 1'b0,
                             8'hFF, 8'hE0)});
    // Halt with zero base cycles; the PC wraps past the top of memory.
    dir_rows.push_back('{insn(FOP_HALT, 8'h00, 2'd1, 3'd0, 2'd3, 16'h0, 16'h0, 2'b00,
                              16'h0), 1'b1,
                         res(16'h0000, STK_NONE, 16'h0, KIND_INSN, 1'b0, 1'b0, 1'b1,
                             8'hFF, 8'hE0)});
    dir_rows.push_back('{insn(FOP_JP, 8'h00, 2'd3, 3'd1, 2'd0, 16'h1234, 16'h0, 2'b00,
                              16'h0), 1'b1,
                         res(16'h0000, STK_NONE, 16'h0, KIND_HALTED, 1'b0, 1'b0, 1'b1,
                             8'hFF, 8'hE0)});
    dir_rows.push_back('{regop(CMD_REQUEST, 3'd4, 8'h00), 1'b1,
                         res(16'h0000, STK_NONE, 16'h0, KIND_REG, 1'b0, 1'b0, 1'b1,
                             8'hFF, 8'hF0)});
    dir_rows.push_back('{insn(FOP_EI_DI, 8'h08, 2'd1, 3'd1, 2'd0, 16'h0, 16'h0, 2'b00,
                              16'h0), 1'b1,
                         res(16'h0001, STK_NONE, 16'h0, KIND_INSN, 1'b0, 1'b1, 1'b0,
                             8'hFF, 8'hF0)});
    dir_rows.push_back('{regop(CMD_REQUEST, 3'd0, 8'h00), 1'b1,
                         res(16'h0001, STK_NONE, 16'h0, KIND_REG, 1'b0, 1'b1, 1'b0,
                             8'hFF, 8'hF1)});
    dir_rows.push_back('{insn(FOP_CALL, 8'h00, 2'd3, 3'd6, 2'd3, 16'h8000, 16'h0, 2'b00,
                              16'h0), 1'b1,
                         res(16'h0040, STK_PUSH, 16'h0001, KIND_IRQ, 1'b0, 1'b0, 1'b0,
                             8'hFF, 8'hF0)});
    // Busy countdown after interrupt entry; the register write does not count down the busy count.
    dir_rows.push_back('{insn(FOP_UNKNOWN, 8'h00, 2'd1, 3'd1, 2'd0, 16'h0, 16'h0, 2'b00,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{regop(CMD_WR_IE, 3'd0, 8'h1F), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_JP, 8'h00, 2'd3, 3'd1, 2'd0, 16'h5555, 16'h0, 2'b00,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_CALL, 8'h00, 2'd3, 3'd1, 2'd0, 16'h5555, 16'h0, 2'b00,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_HALT, 8'h00, 2'd1, 3'd1, 2'd0, 16'h0, 16'h0, 2'b00,
                              16'h0), 1'b0, '0});
    // Most negative relative offset, then a taken jr on carry.
    dir_rows.push_back('{insn(FOP_JR, 8'h00, 2'd2, 3'd1, 2'd0, 16'h0080, 16'h0, 2'b00,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_JR_CC, 8'h18, 2'd2, 3'd1, 2'd0, 16'hFF7F, 16'h0, 2'b01,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_CALL_CC, 8'h00, 2'd3, 3'd1, 2'd3, 16'h2000, 16'h0, 2'b10,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_CALL, 8'h00, 2'd3, 3'd1, 2'd0, 16'h1234, 16'h0, 2'b00,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_RET_CC, 8'h08, 2'd1, 3'd1, 2'd0, 16'h0, 16'h0, 2'b10,
                              16'hBEEF), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_RST, 8'hFF, 2'd1, 3'd1, 2'd0, 16'h0, 16'h0, 2'b00,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_JP_CC, 8'h10, 2'd3, 3'd1, 2'd0, 16'hA5A5, 16'h0, 2'b00,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_JP_HL, 8'h00, 2'd1, 3'd1, 2'd0, 16'h0, 16'hFFFF, 2'b00,
                              16'h0), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_RET, 8'h00, 2'd1, 3'd1, 2'd0, 16'h0, 16'h0, 2'b00,
                              16'h0000), 1'b0, '0});
    dir_rows.push_back('{insn(FOP_RETI, 8'h00, 2'd1, 3'd1, 2'd0, 16'h0, 16'h0, 2'b00,
                              16'h0100), 1'b0, '0});
    // Source 4 is still pending and enabled, so this tick enters its vector.
    dir_rows.push_back('{insn(FOP_NOP, 8'h00, 2'd0, 3'd1, 2'd0, 16'h0, 16'h0, 2'b00,
                              16'h0), 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) send_item(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);
    settle();
    write_idle(4'd0);
    run_random(300);
    settle();
    write_idle(4'd15);
    run_random(300);
    settle();
    write_idle(4'($urandom_range(1, 14)));
    run_random(250);
    settle();
    write_idle(4'($urandom_range(0, 15)));
    quiet <= 1'b1;
    run_random(250);
    settle();

    if (fail_count == 0 && due_steps.size() == 0) begin
      $display("[cpu_interrupt_and_branch_control_unit] OK");
    end else begin
      $display("[cpu_interrupt_and_branch_control_unit] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cibc_pkg.sv
rtl/cpu_interrupt_and_branch_control_unit.sv
rtl/cibc_checker.sv
verif/tb_cpu_interrupt_and_branch_control_unit.sv
